// File: rtl/integer_literal_parser_core_assert.svh
// Assertion macros for the integer literal parser checker.
// Included by the checker file; depends on nothing else.
`ifndef INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, quiet while reset is held.
`define ILP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while reset is held.
`define ILP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked across reset as well.
`define ILP_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ilp_pkg.sv
// Shared types and constants of the integer literal parser.
// Used by every module of the block; depends on nothing.
package ilp_pkg;

    localparam int CH_W       = 8;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int STATUS_LSB = VAL_W;
    localparam int PAD_W      = M_TDATA_W - VAL_W - ST_W;

    // Character codes the parser looks for.
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_A     = 8'h41;
    localparam logic [CH_W-1:0] CH_F     = 8'h46;
    localparam logic [CH_W-1:0] CH_K     = 8'h4B;
    localparam logic [CH_W-1:0] CH_M     = 8'h4D;
    localparam logic [CH_W-1:0] CH_X     = 8'h58;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CASE_GAP = 8'h20;
    localparam logic [3:0]      HEX_ALPHA_OFS = 4'd9;

    localparam logic [VAL_W-1:0] RANGE_HIGH_RST = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DEC,
        PH_HEX,
        PH_SUFFIX,
        PH_BAD
    } phase_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_NAN,
        ST_RANGE
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_EN,
        CFG_RANGE_LOW,
        CFG_RANGE_HIGH
    } cfg_idx_t;

    typedef struct packed {
        phase_t           phase;
        logic [VAL_W-1:0] acc;
        logic             neg;
    } ilp_state_t;

    typedef struct packed {
        logic                    range_en;
        logic signed [VAL_W-1:0] range_low;
        logic signed [VAL_W-1:0] range_high;
    } ilp_cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        status_t                 status;
    } ilp_result_t;

endpackage

// File: rtl/ilp_step.sv
// Per-byte parse step: next phase, accumulator update and field result.
// Purely combinational; depends on ilp_pkg.
module ilp_step
    import ilp_pkg::*;
(
    input  logic [CH_W-1:0] ch,
    input  ilp_state_t      cur,
    input  ilp_cfg_t        cfg,
    output ilp_state_t      nxt,
    output logic            term,
    output ilp_result_t     result
);

    logic [CH_W-1:0]  up;
    logic             is_digit;
    logic             is_nonzero_digit;
    logic             is_hex_alpha;
    logic             is_suffix;
    logic [3:0]       hex_digit;
    logic [VAL_W-1:0] acc_dec;
    logic [VAL_W-1:0] acc_hex;
    logic [VAL_W-1:0] acc_tail;
    logic signed [VAL_W-1:0] mag;
    phase_t           tail_phase;
    phase_t           nxt_phase;
    logic [VAL_W-1:0] nxt_acc;
    logic             nxt_neg;

    assign term = (ch == CH_NUL) || (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign up   = ((ch >= CH_LA) && (ch <= CH_LZ)) ? ch - CASE_GAP : ch;

    assign is_digit         = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_nonzero_digit = (ch >= CH_ONE) && (ch <= CH_NINE);
    assign is_hex_alpha     = (up >= CH_A) && (up <= CH_F);
    assign is_suffix        = (up == CH_K) || (up == CH_M);
    assign hex_digit        = is_hex_alpha ? up[3:0] + HEX_ALPHA_OFS : up[3:0];

    // Times ten as two shifts and an add, then the new digit.
    assign acc_dec = {cur.acc[VAL_W-4:0], 3'b000} + {cur.acc[VAL_W-2:0], 1'b0}
                   + {{(VAL_W-4){1'b0}}, ch[3:0]};
    assign acc_hex = {cur.acc[VAL_W-5:0], hex_digit};
    assign acc_tail = (up == CH_K) ? {cur.acc[VAL_W-11:0], 10'b0}
                                   : {cur.acc[VAL_W-21:0], 20'b0};
    assign tail_phase = is_suffix ? PH_SUFFIX : PH_BAD;
    assign mag = cur.acc;

    assign nxt = '{phase: nxt_phase, acc: nxt_acc, neg: nxt_neg};

    // Next phase.
    always_comb begin
        nxt_phase = PH_BAD;
        if (term) begin
            nxt_phase = PH_START;
        end else begin
            unique case (cur.phase)
                PH_START: begin
                    if (ch == CH_MINUS)     nxt_phase = PH_SIGNED;
                    else if (ch == CH_ZERO) nxt_phase = PH_ZERO;
                    else if (is_digit)      nxt_phase = PH_DEC;
                    else                    nxt_phase = PH_BAD;
                end
                PH_SIGNED: begin
                    if (ch == CH_ZERO)      nxt_phase = PH_ZERO;
                    else if (is_digit)      nxt_phase = PH_DEC;
                    else                    nxt_phase = tail_phase;
                end
                PH_ZERO: begin
                    if (up == CH_X)         nxt_phase = PH_HEX;
                    else if (is_digit)      nxt_phase = PH_DEC;
                    else                    nxt_phase = tail_phase;
                end
                PH_DEC: begin
                    nxt_phase = is_digit ? PH_DEC : tail_phase;
                end
                PH_HEX: begin
                    nxt_phase = (is_digit || is_hex_alpha) ? PH_HEX : tail_phase;
                end
                default: begin
                    nxt_phase = PH_BAD;
                end
            endcase
        end
    end

    // Accumulator, sign and the result released by a terminator.
    always_comb begin
        nxt_acc       = cur.acc;
        nxt_neg       = cur.neg;
        result.value  = '0;
        result.status = ST_OK;
        if (term) begin
            nxt_acc = '0;
            nxt_neg = 1'b0;
            if ((cur.phase == PH_START) || (cur.phase == PH_BAD) || (cur.phase > PH_BAD)) begin
                result.status = ST_NAN;
            end else if (cfg.range_en && ((cfg.range_low > mag) || (mag > cfg.range_high))) begin
                result.status = ST_RANGE;
            end else begin
                result.value = cur.neg ? -cur.acc : cur.acc;
            end
        end else begin
            unique case (cur.phase)
                PH_START: begin
                    if (ch == CH_MINUS)        nxt_neg = 1'b1;
                    else if (is_nonzero_digit) nxt_acc = {{(VAL_W-4){1'b0}}, ch[3:0]};
                end
                PH_SIGNED: begin
                    if (is_nonzero_digit)      nxt_acc = {{(VAL_W-4){1'b0}}, ch[3:0]};
                    else if (!is_digit && is_suffix) nxt_acc = acc_tail;
                end
                PH_ZERO, PH_DEC: begin
                    // In the zero phase an 'x' only moves to hex and keeps the value.
                    if (is_digit)              nxt_acc = acc_dec;
                    else if (is_suffix)        nxt_acc = acc_tail;
                end
                PH_HEX: begin
                    if (is_digit || is_hex_alpha) nxt_acc = acc_hex;
                    else if (is_suffix)           nxt_acc = acc_tail;
                end
                default: begin
                    nxt_acc = cur.acc;
                end
            endcase
        end
    end

endmodule

// File: rtl/ilp_out_reg.sv
// Result register of the integer literal parser, held until taken.
// Depends on ilp_pkg.
module ilp_out_reg
    import ilp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  ilp_result_t load_result,
    input  logic        m_tready,
    output logic        m_tvalid,
    output ilp_result_t out_result,
    output logic        free
);

    logic        valid_reg;
    logic        valid_next;
    ilp_result_t result_reg;

    // The slot can take a new result when empty or being drained now.
    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign m_tvalid   = valid_reg;
    assign out_result = result_reg;

endmodule

// File: rtl/integer_literal_parser_core.sv
// Integer literal parser top level: input byte register, parse state,
// configuration registers and result register. Depends on ilp_pkg,
// ilp_step and ilp_out_reg.
//
// Usage:
//   The s_ channel carries one ASCII byte per word. Bytes of a field are
//   an optional '-', a decimal number or 0x/0X and hex digits, and an
//   optional K or M suffix. A whitespace or NUL byte ends the field and
//   produces exactly one word on the m_ channel: the signed value in
//   bits 31:0 and the status (0 ok, 1 not a number, 2 out of range) in
//   bits 33:32. Other bytes produce no output word.
//   The cfg channel writes range_enable (index 0), range_low (index 1)
//   and range_high (index 2); it is always ready and should be used only
//   while no field is in flight.
// Pipeline and throughput:
//   A byte is registered on acceptance and parsed there; a terminator's
//   result goes on to the result register. One byte is accepted every
//   cycle while no terminator waits on a full slot; the single parse step
//   (a multiply by ten and an add, or a range compare) sets that rate.
// Reset and stalls:
//   aresetn (synchronous, active low) empties both registers, clears the
//   field state and loads the register defaults. While the receiver holds
//   m_tready low, a pending result stays put; digits keep flowing in and
//   only a second terminator waits in the input register.
module integer_literal_parser_core
    import ilp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input byte channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [7:0] ch
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [31:0] value, [33:32] status, [39:34] zero
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic            in_valid_reg;
    logic            in_valid_next;
    logic [CH_W-1:0] in_ch_reg;
    ilp_state_t      state_reg;
    ilp_state_t      state_next;
    ilp_cfg_t        cfg_reg;
    ilp_result_t     step_result;
    ilp_result_t     out_result;
    logic            term;
    logic            out_free;
    logic            advance;
    logic            s_accept;

    // The held byte moves on unless it is a terminator and the result slot
    // is still occupied.
    assign advance       = in_valid_reg && (!term || out_free);
    assign s_tready      = !in_valid_reg || advance;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_ch_reg <= s_tdata[CH_W-1:0];
        end
    end

    // Field state advances once per parsed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= PH_START;
            state_reg.acc   <= '0;
            state_reg.neg   <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Configuration registers; an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_en   <= 1'b0;
            cfg_reg.range_low  <= '0;
            cfg_reg.range_high <= RANGE_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RANGE_EN:   cfg_reg.range_en   <= cfg_data[0];
                CFG_RANGE_LOW:  cfg_reg.range_low  <= cfg_data[VAL_W-1:0];
                CFG_RANGE_HIGH: cfg_reg.range_high <= cfg_data[VAL_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    ilp_step u_step (
        .ch     (in_ch_reg),
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .nxt    (state_next),
        .term   (term),
        .result (step_result)
    );

    ilp_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && term),
        .load_result (step_result),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_result  (out_result),
        .free        (out_free)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_result.status, out_result.value};

endmodule

// File: rtl/ilp_checker.sv
// Port-level checker for the integer literal parser, bound to the top.
// Depends on ilp_pkg and integer_literal_parser_core_assert.svh.
`include "integer_literal_parser_core_assert.svh"

module ilp_checker
    import ilp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // The status field never carries the unused code.
    `ILP_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[STATUS_LSB +: ST_W] != 2'b11, "bad status code")

    // A failed field always reports a zero value.
    `ILP_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tdata[STATUS_LSB +: ST_W] != ST_OK), m_tdata[VAL_W-1:0] == '0, "failed field with nonzero value")

    // A stalled result stays and does not change.
    `ILP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed under stall")

    // No result is offered right after reset.
    `ILP_ASSERT_RESET(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind integer_literal_parser_core ilp_checker u_ilp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/tb.sv
// Self-checking testbench for integer_literal_parser_core: feeds ASCII number fields,
// predicts every parsed result and compares it with the m_ channel word by word.
// Depends on ilp_pkg and on the RTL of the parser core.
module tb;
    import ilp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of rows in the directed stimulus table.
    localparam int N_DIRECTED = 27;
    // Byte count, directed part included, after which no new random phase starts.
    localparam int N_RANDOM = 1950;
    // Cycles allowed after the last result for the two-stage pipeline to drain.
    localparam int DRAIN_CYCLES = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;      // [7:0] ch
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [31:0] value, [33:32] status, [39:34] zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    integer_literal_parser_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock, high and low for one nanosecond each.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // One row of the directed table. When reconfig is set, the range registers are
    // rewritten (with the block idle) before the field is sent. When typed is set,
    // the expected result is the one given in the row; otherwise the predictor
    // supplies it.
    typedef struct {
        bit          reconfig;
        bit          en;
        logic [31:0] lo;
        logic [31:0] hi;
        string       text;
        logic [7:0]  term;
        bit          typed;
        logic [31:0] value;
        status_t     status;
    } field_row_t;

    // Line feed, vertical tab and form feed sit between tab and carriage return.
    localparam logic [7:0] CH_LF = CH_TAB + 8'd1;
    localparam logic [7:0] CH_VT = CH_TAB + 8'd2;
    localparam logic [7:0] CH_FF = CH_TAB + 8'd3;

    field_row_t directed_rows[N_DIRECTED] = '{
        // Empty field right after reset.
        '{0, 0, 0, 0, "",            CH_NUL,   1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "0",           CH_SPACE, 1, 32'h0000_0000, ST_OK},
        // Largest and smallest values, then wrap-around of the magnitude.
        '{0, 0, 0, 0, "2147483647",  CH_TAB,   1, 32'h7FFF_FFFF, ST_OK},
        '{0, 0, 0, 0, "-2147483648", CH_LF,    1, 32'h8000_0000, ST_OK},
        '{0, 0, 0, 0, "4294967295",  CH_VT,    1, 32'hFFFF_FFFF, ST_OK},
        '{0, 0, 0, 0, "0xFFFFFFFF",  CH_FF,    1, 32'hFFFF_FFFF, ST_OK},
        '{0, 0, 0, 0, "0Xdeadbeef",  CH_CR,    0, 32'h0,         ST_OK},
        // A bare sign, with or without a suffix, and a bare hex prefix read as zero.
        '{0, 0, 0, 0, "-",           CH_SPACE, 1, 32'h0000_0000, ST_OK},
        '{0, 0, 0, 0, "-K",          CH_SPACE, 1, 32'h0000_0000, ST_OK},
        '{0, 0, 0, 0, "-m",          CH_NUL,   1, 32'h0000_0000, ST_OK},
        '{0, 0, 0, 0, "0x",          CH_SPACE, 1, 32'h0000_0000, ST_OK},
        // Suffixes in both cases.
        '{0, 0, 0, 0, "12k",         CH_SPACE, 0, 32'h0,         ST_OK},
        '{0, 0, 0, 0, "-3M",         CH_SPACE, 0, 32'h0,         ST_OK},
        '{0, 0, 0, 0, "0x1K",        CH_TAB,   0, 32'h0,         ST_OK},
        // Bad bytes, including bytes after the suffix, give a zero value; then leading zeros and a wrapping decimal.
        '{0, 0, 0, 0, "12a3",        CH_SPACE, 1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "5Kx",         CH_SPACE, 1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "5mm",         CH_SPACE, 1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "+5",          CH_SPACE, 1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "0x0g1",       CH_SPACE, 1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "1\377",       CH_SPACE, 1, 32'h0000_0000, ST_NAN},
        '{0, 0, 0, 0, "0078",        CH_SPACE, 0, 32'h0,         ST_OK},
        '{0, 0, 0, 0, "99999999999", CH_SPACE, 0, 32'h0,         ST_OK},
        // Range check on the magnitude, before the sign is applied.
        '{1, 1, 32'd0, 32'd1000, "1000",  CH_SPACE, 1, 32'd1000,      ST_OK},
        '{0, 0, 0, 0, "1001",        CH_SPACE, 1, 32'h0000_0000, ST_RANGE},
        '{0, 0, 0, 0, "-1K",         CH_SPACE, 1, 32'h0000_0000, ST_RANGE},
        // A window of negative magnitudes, reachable only through wrap-around.
        '{1, 1, 32'h8000_0000, 32'hFFFF_FFFF, "4294967295", CH_SPACE,
          1, 32'hFFFF_FFFF, ST_OK},
        '{0, 0, 0, 0, "7",           CH_SPACE, 1, 32'h0000_0000, ST_RANGE}
    };

    // Predictor state: the field being parsed and the range registers.
    phase_t      fld_phase = PH_START;
    logic [31:0] fld_mag = '0;
    logic        fld_neg = 1'b0;
    ilp_cfg_t    range_cfg = '{1'b0, 32'sd0, RANGE_HIGH_RST};

    // Results that the block still owes, oldest first.
    ilp_result_t pending_values[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    bit          sender_burst = 1'b0;

    // A suffix after at least one consumed byte scales the magnitude; any other
    // byte spoils the field.
    function automatic void take_suffix(input logic [7:0] u);
        if (u == CH_K) begin
            fld_mag   = fld_mag << 10;
            fld_phase = PH_SUFFIX;
        end else if (u == CH_M) begin
            fld_mag   = fld_mag << 20;
            fld_phase = PH_SUFFIX;
        end else begin
            fld_phase = PH_BAD;
        end
    endfunction

    // Advances the field state by one byte. Returns 1 and fills res when the
    // byte is a terminator, which always releases exactly one result.
    function automatic bit parse_char(input logic [7:0] c, output ilp_result_t res);
        logic [7:0]        u;
        logic signed [31:0] mag;
        bit                 is_digit;
        u = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        res = '{32'sd0, ST_OK};
        if (c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (fld_phase == PH_START || fld_phase == PH_BAD) begin
                res.status = ST_NAN;
            end else begin
                mag = $signed(fld_mag);
                if (range_cfg.range_en && ($signed(range_cfg.range_low) > mag ||
                                           mag > $signed(range_cfg.range_high)))
                    res.status = ST_RANGE;
                else
                    res.value = fld_neg ? 32'd0 - fld_mag : fld_mag;
            end
            fld_phase = PH_START;
            fld_mag   = '0;
            fld_neg   = 1'b0;
            return 1'b1;
        end
        case (fld_phase)
            PH_START, PH_SIGNED: begin
                if (fld_phase == PH_START && c == CH_MINUS) begin
                    fld_neg   = 1'b1;
                    fld_phase = PH_SIGNED;
                end else if (c == CH_ZERO) begin
                    fld_phase = PH_ZERO;
                end else if (is_digit) begin
                    fld_mag   = 32'(c - CH_ZERO);
                    fld_phase = PH_DEC;
                end else if (fld_phase == PH_START) begin
                    fld_phase = PH_BAD;
                end else begin
                    take_suffix(u);
                end
            end
            PH_ZERO, PH_DEC: begin
                // A leading zero followed by X opens a hex number; otherwise the
                // zero simply counts as a decimal digit.
                if (fld_phase == PH_ZERO && u == CH_X) begin
                    fld_phase = PH_HEX;
                end else if (is_digit) begin
                    fld_mag   = fld_mag * 32'd10 + 32'(c - CH_ZERO);
                    fld_phase = PH_DEC;
                end else begin
                    take_suffix(u);
                end
            end
            PH_HEX: begin
                if (is_digit)
                    fld_mag = {fld_mag[27:0], 4'(c - CH_ZERO)};
                else if (u >= CH_A && u <= CH_F)
                    fld_mag = {fld_mag[27:0], 4'(u - CH_A + 8'd10)};
                else
                    take_suffix(u);
            end
            default: fld_phase = PH_BAD;
        endcase
        return 1'b0;
    endfunction

    // Sender gap: mostly back to back, sometimes short, rarely long.
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Drives one byte on the s_ channel and, once it is accepted, runs the
    // predictor. A row with a typed result queues that result instead.
    task automatic send_char(input logic [7:0] c, input bit typed, input ilp_result_t typed_res);
        int          gap;
        ilp_result_t res;
        gap = next_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (parse_char(c, res))
            pending_values.push_back(typed ? typed_res : res);
    endtask

    // Stops sending, holds off until the block owes nothing, then lets the
    // pipeline settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_values.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RANGE_EN:   range_cfg.range_en   = d[0];
            CFG_RANGE_LOW:  range_cfg.range_low  = d;
            CFG_RANGE_HIGH: range_cfg.range_high = d;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Rewrites all three range registers; callers make sure the block is idle.
    task automatic set_range(input bit en, input logic [31:0] lo, input logic [31:0] hi);
        write_reg(CFG_RANGE_EN, {31'd0, en});
        write_reg(CFG_RANGE_LOW, lo);
        write_reg(CFG_RANGE_HIGH, hi);
    endtask

    // Builds one field and sends it, terminator included. Most fields are
    // well formed with random content; some carry a bad byte, and a few are
    // pure noise covering every byte value.
    task automatic send_random_field();
        logic [7:0] chars[$];
        int         kind;
        int         n;
        int         d;
        int         r;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            n = $urandom_range(0, 6);
            repeat (n) chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0)
                chars.push_back(CH_MINUS);
            if ($urandom_range(0, 2) == 0) begin
                chars.push_back(CH_ZERO);
                chars.push_back($urandom_range(0, 1) ? CH_X : CH_X + CASE_GAP);
                n = $urandom_range(0, 9);
                repeat (n) begin
                    d = $urandom_range(0, 15);
                    if (d < 10)
                        chars.push_back(CH_ZERO + 8'(d));
                    else
                        chars.push_back(CH_A + 8'(d - 10) +
                                        ($urandom_range(0, 1) ? CASE_GAP : 8'd0));
                end
            end else begin
                // Short numbers are common so that small range windows get hits.
                n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 12);
                repeat (n) chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 3);
                chars.push_back((r[0] ? CH_K : CH_M) + (r[1] ? CASE_GAP : 8'd0));
            end
            if (kind < 25)
                chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 6);
        chars.push_back(r == 0 ? CH_NUL : r == 1 ? CH_SPACE : CH_TAB + 8'(r - 2));
        foreach (chars[i])
            send_char(chars[i], 1'b0, '{32'sd0, ST_OK});
    endtask

    // Result checker: every accepted word must match the oldest expectation.
    always @(posedge aclk) begin
        ilp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result word: value 0x%08h, status %0d",
                       m_tdata[VAL_W-1:0], m_tdata[STATUS_LSB +: ST_W]);
                mismatch_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_tdata[VAL_W-1:0] !== want.value) begin
                    $error("value: expected 0x%08h, actual 0x%08h",
                           want.value, m_tdata[VAL_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[STATUS_LSB +: ST_W] !== want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, m_tdata[STATUS_LSB +: ST_W]);
                    mismatch_count++;
                end
                if (m_tdata[M_TDATA_W-1 -: PAD_W] !== '0) begin
                    $error("pad: expected 0x0, actual 0x%0h", m_tdata[M_TDATA_W-1 -: PAD_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: alternates between stretches of constant readiness and
    // stretches of random back-pressure with occasional long stalls.
    int ready_mode_left = 0;
    int ready_stall_left = 0;
    bit ready_free = 1'b0;
    always @(negedge aclk) begin
        int r;
        if (ready_mode_left == 0) begin
            ready_free      = ($urandom_range(0, 3) == 0);
            ready_mode_left = $urandom_range(20, 200);
        end else begin
            ready_mode_left--;
        end
        r = $urandom_range(0, 99);
        if (ready_free) begin
            m_tready = 1'b1;
        end else if (ready_stall_left > 0) begin
            ready_stall_left--;
            m_tready = 1'b0;
        end else if (r < 4) begin
            ready_stall_left = $urandom_range(8, 40);
            m_tready = 1'b0;
        end else begin
            m_tready = (r >= 30);
        end
    end

    // Main sequence: reset, directed table, then random phases, each phase
    // under its own range setting.
    initial begin
        int          phase_end;
        int          mode;
        logic [31:0] lo;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].reconfig) begin
                wait_idle();
                set_range(directed_rows[i].en, directed_rows[i].lo, directed_rows[i].hi);
            end
            for (int k = 0; k < directed_rows[i].text.len(); k++)
                send_char(directed_rows[i].text[k], 1'b0, '{32'sd0, ST_OK});
            send_char(directed_rows[i].term, directed_rows[i].typed,
                      '{directed_rows[i].value, directed_rows[i].status});
        end

        while (bytes_sent < N_RANDOM) begin
            // The sender holds off here until every owed result has arrived.
            wait_idle();
            mode = $urandom_range(0, 5);
            case (mode)
                0: set_range(1'b0, $urandom(), $urandom());
                1: set_range(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
                2: set_range(1'b1, 32'd0, $urandom_range(0, 100000));
                3: begin
                    lo = $urandom_range(0, 5000);
                    set_range(1'b1, lo, lo + $urandom_range(0, 1000000));
                end
                4: set_range(1'b1, $urandom(), $urandom());
                default: set_range(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            endcase
            sender_burst = ($urandom_range(0, 3) == 0);
            phase_end = bytes_sent + $urandom_range(100, 300);
            while (bytes_sent < phase_end) begin
                send_random_field();
                // Now and then the sender drains the result queue mid-phase.
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_values.size() != 0)
            @(posedge aclk);
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ilp_pkg.sv
rtl/ilp_step.sv
rtl/ilp_out_reg.sv
rtl/integer_literal_parser_core.sv
rtl/ilp_checker.sv
sim/tb.sv
